// File: src/jse_pkg.sv
// Shared types, character constants and helper functions for the JSON string escaper.
`default_nettype none

package jse_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
  localparam int unsigned PosW       = 3;
  localparam int unsigned SeqLenW    = 4;
  localparam int unsigned BodyLenW   = 3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CTRL_MAX  = 8'h1F;

  // How the body of one input byte is written out.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_PLAIN,
    KIND_SHORT,
    KIND_UNI
  } kind_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic       open_q;
    logic       close_q;
    kind_t      kind;
    logic [7:0] ch;
  } desc_t;

  function automatic logic [BodyLenW-1:0] body_len(input kind_t kind);
    logic [BodyLenW-1:0] len;
    unique case (kind)
      KIND_NONE:  len = BodyLenW'(0);
      KIND_PLAIN: len = BodyLenW'(1);
      KIND_SHORT: len = BodyLenW'(2);
      KIND_UNI:   len = BodyLenW'(6);
      default:    len = BodyLenW'(0);
    endcase
    return len;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = CH_ZERO + {4'd0, nib};
    end else begin
      d = CH_UPPER_A + {4'd0, nib} - 8'd10;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: src/jse_front.sv
// Front end: classifies each accepted byte into an escape request for the queue.
`default_nettype none

module jse_front (
  input  wire logic          s_valid,
  input  wire logic          q_full,
  input  wire logic [7:0]    in_byte,
  input  wire logic          first_of_string,
  input  wire logic          last_of_string,
  input  wire logic          empty_string,
  output logic               s_ready,
  output logic               push,
  output jse_pkg::desc_t     push_desc
);

  jse_pkg::kind_t kind;
  logic [7:0]     ch;

  always_comb begin
    kind = jse_pkg::KIND_PLAIN;
    ch   = in_byte;
    unique case (in_byte)
      jse_pkg::CH_QUOTE:  begin kind = jse_pkg::KIND_SHORT; ch = jse_pkg::CH_QUOTE;  end
      jse_pkg::CH_BSLASH: begin kind = jse_pkg::KIND_SHORT; ch = jse_pkg::CH_BSLASH; end
      jse_pkg::CH_BS:     begin kind = jse_pkg::KIND_SHORT; ch = jse_pkg::CH_LOW_B;  end
      jse_pkg::CH_FF:     begin kind = jse_pkg::KIND_SHORT; ch = jse_pkg::CH_LOW_F;  end
      jse_pkg::CH_LF:     begin kind = jse_pkg::KIND_SHORT; ch = jse_pkg::CH_LOW_N;  end
      jse_pkg::CH_CR:     begin kind = jse_pkg::KIND_SHORT; ch = jse_pkg::CH_LOW_R;  end
      jse_pkg::CH_TAB:    begin kind = jse_pkg::KIND_SHORT; ch = jse_pkg::CH_LOW_T;  end
      default: begin
        if (in_byte <= jse_pkg::CTRL_MAX) begin
          kind = jse_pkg::KIND_UNI;
        end
      end
    endcase
    // An empty string carries no body, only the two quotes.
    if (empty_string) begin
      kind = jse_pkg::KIND_NONE;
    end
  end

  assign s_ready           = !q_full;
  assign push              = s_valid && !q_full;
  assign push_desc.open_q  = first_of_string || empty_string;
  assign push_desc.close_q = last_of_string || empty_string;
  assign push_desc.kind    = kind;
  assign push_desc.ch      = ch;

endmodule

`default_nettype wire

// File: src/jse_queue.sv
// Short request queue between the classifying front and the emitting back.
`default_nettype none

module jse_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire jse_pkg::desc_t  push_desc,
  input  wire logic            pop,
  output logic                 full,
  output logic                 head_valid,
  output jse_pkg::desc_t       head_desc
);

  jse_pkg::desc_t                 mem [jse_pkg::QueueDepth];
  logic [jse_pkg::QueuePtrW-1:0]  wr_ptr;
  logic [jse_pkg::QueuePtrW-1:0]  rd_ptr;
  logic [jse_pkg::QueueCntW-1:0]  count;

  assign full       = (count == jse_pkg::QueueCntW'(jse_pkg::QueueDepth));
  assign head_valid = (count != '0);
  assign head_desc  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/jse_back.sv
// Back end: walks the head request byte by byte into the registered output stage.
`default_nettype none

module jse_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  input  wire jse_pkg::desc_t  head_desc,
  output logic                 pop,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [7:0]           m_tdata,
  output logic                 m_tlast
);

  logic [jse_pkg::PosW-1:0]     pos;
  logic [jse_pkg::BodyLenW-1:0] blen;
  logic [jse_pkg::SeqLenW-1:0]  seq_len;
  logic [jse_pkg::PosW-1:0]     bidx;
  logic                         emit;
  logic                         final_byte;
  logic [7:0]                   body_byte;
  logic [7:0]                   cur_byte;
  logic                         cur_last;

  assign blen    = jse_pkg::body_len(head_desc.kind);
  assign seq_len = jse_pkg::SeqLenW'(head_desc.open_q) + jse_pkg::SeqLenW'(blen)
                 + jse_pkg::SeqLenW'(head_desc.close_q);
  assign bidx    = pos - jse_pkg::PosW'(head_desc.open_q);
  assign final_byte = ({1'b0, pos} == seq_len - 1'b1);
  assign emit    = head_valid && (!m_tvalid || m_tready);
  assign pop     = emit && final_byte;

  always_comb begin
    body_byte = head_desc.ch;
    unique case (head_desc.kind)
      jse_pkg::KIND_SHORT: begin
        body_byte = (bidx == '0) ? jse_pkg::CH_BSLASH : head_desc.ch;
      end
      jse_pkg::KIND_UNI: begin
        unique case (bidx)
          3'd0:    body_byte = jse_pkg::CH_BSLASH;
          3'd1:    body_byte = jse_pkg::CH_LOW_U;
          3'd4:    body_byte = jse_pkg::hex_digit(head_desc.ch[7:4]);
          3'd5:    body_byte = jse_pkg::hex_digit(head_desc.ch[3:0]);
          default: body_byte = jse_pkg::CH_ZERO;
        endcase
      end
      default: body_byte = head_desc.ch;
    endcase
  end

  always_comb begin
    cur_last = 1'b0;
    if (head_desc.open_q && pos == '0) begin
      cur_byte = jse_pkg::CH_QUOTE;
    end else if ({1'b0, bidx} < jse_pkg::SeqLenW'(blen)) begin
      cur_byte = body_byte;
    end else begin
      cur_byte = jse_pkg::CH_QUOTE;
      cur_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        pos      <= final_byte ? '0 : pos + 1'b1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= cur_byte;
      m_tlast <= cur_last;
    end
  end

endmodule

`default_nettype wire

// File: src/json_string_escaper_unit.sv
// Top level of the JSON string escaper: front classifier, request queue and byte emitter.
//
//   channel   dir  tdata         tuser                              tlast
//   s_*       in   in_byte[7:0]  [0] first_of_string [1] empty_string  last_of_string
//   m_*       out  out_byte[7:0] -                                  out_last
//
// An input byte becomes one to eight output bytes (quotes plus zero, one, two or six
// body bytes) through the single-byte output register. Plain bytes flow at one per
// cycle unless the output stalls; escapes stall input once the four-entry queue fills.
// Synchronous reset empties the queue and drops any pending output byte.
// A stalled output holds its byte while the front keeps filling the queue.
`default_nettype none

module json_string_escaper_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic [1:0] s_tuser,   // [0] first_of_string, [1] empty_string
  input  wire logic       s_tlast,   // last_of_string
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast    // out_last
);

  logic           q_full;
  logic           push;
  jse_pkg::desc_t push_desc;
  logic           pop;
  logic           head_valid;
  jse_pkg::desc_t head_desc;

  jse_front u_front (
    .s_valid         (s_tvalid),
    .q_full          (q_full),
    .in_byte         (s_tdata),
    .first_of_string (s_tuser[0]),
    .last_of_string  (s_tlast),
    .empty_string    (s_tuser[1]),
    .s_ready         (s_tready),
    .push            (push),
    .push_desc       (push_desc)
  );

  jse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  jse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire

// File: src/jse_checker.sv
// Port-level checks on the JSON string escaper, bound to its top level.
`default_nettype none

module jse_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic [7:0] s_tdata,
  input wire logic [1:0] s_tuser,
  input wire logic       s_tlast,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_rst_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  a_last_is_quote: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata == jse_pkg::CH_QUOTE))
    else $error("closing byte is not a quote");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output changed");

  // A waiting request must not change until the block takes it.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !s_tready) |=>
      (s_tvalid && $stable(s_tdata) && $stable(s_tuser) && $stable(s_tlast)))
    else $error("waiting request changed");

endmodule

bind json_string_escaper_unit jse_checker u_jse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
